@@ rtl/hac_pkg.sv @@
`timescale 1ns / 1ps

package hac_pkg;

    localparam int GUARD_SHIFT = 8;
    localparam int Z_FRAC      = 24;
    localparam int TAB_LEN     = 24;
    localparam int ZW          = 34;
    localparam int HEAD_W      = 16;
    localparam int IN_W        = 16;
    localparam int EXT_W       = 32;

    typedef logic signed [ZW-1:0] zang_t;

    // special-case codes carried down the pipe
    localparam logic [2:0] SP_NONE = 3'd0;
    localparam logic [2:0] SP_ZERO = 3'd1;
    localparam logic [2:0] SP_180  = 3'd2;
    localparam logic [2:0] SP_M90  = 3'd3;
    localparam logic [2:0] SP_P90  = 3'd4;

    localparam zang_t Z_P90 = 34'sd1509949440;

    typedef struct packed {
        logic       vld;
        logic [2:0] sp;
    } hac_ctl_t;

    // arctangent of 2^-i in 2^-24 degree
    function automatic zang_t atan_tab(input logic [4:0] idx);
        zang_t r;
        case (idx)
            5'd0:    r = 34'sd754974720;
            5'd1:    r = 34'sd445687602;
            5'd2:    r = 34'sd235489088;
            5'd3:    r = 34'sd119537938;
            5'd4:    r = 34'sd60000934;
            5'd5:    r = 34'sd30029717;
            5'd6:    r = 34'sd15018523;
            5'd7:    r = 34'sd7509720;
            5'd8:    r = 34'sd3754917;
            5'd9:    r = 34'sd1877466;
            5'd10:   r = 34'sd938734;
            5'd11:   r = 34'sd469367;
            5'd12:   r = 34'sd234684;
            5'd13:   r = 34'sd117342;
            5'd14:   r = 34'sd58671;
            5'd15:   r = 34'sd29335;
            5'd16:   r = 34'sd14668;
            5'd17:   r = 34'sd7334;
            5'd18:   r = 34'sd3667;
            5'd19:   r = 34'sd1833;
            5'd20:   r = 34'sd917;
            5'd21:   r = 34'sd458;
            5'd22:   r = 34'sd229;
            5'd23:   r = 34'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/heading_angle_atan2_core.sv @@
`timescale 1ns / 1ps

// heading toward a target offset (dx, dy) by cordic vectoring, zero along +y and
// counter-clockwise positive, in 1/2^ANGLE_FRAC_BITS degree, saturated to +-180.
// busy is always low: a request is taken every clock and a result comes out on
// heading with done high after one input stage with the quadrant pre-rotation,
// one cell per micro-rotation, and one rounding stage. results cannot be held off,
// so take them when done is high.

module heading_angle_atan2_core
    import hac_pkg::*;
#(
    parameter int ITERATIONS      = 16,
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 7
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [IN_W-1:0]   dx,
    input  logic signed [IN_W-1:0]   dy,
    output logic                     done,
    output logic signed [HEAD_W-1:0] heading
);

    localparam int W   = COORD_BITS + GUARD_SHIFT + 3;
    localparam int LAT = ITERATIONS + 2;

    logic signed [W-1:0] p_pipe [0:ITERATIONS];
    logic signed [W-1:0] q_pipe [0:ITERATIONS];
    zang_t               z_pipe [0:ITERATIONS];
    hac_ctl_t            c_pipe [0:ITERATIONS];

    assign busy = 1'b0;

    hac_prerot #(
        .COORD_BITS (COORD_BITS),
        .W          (W)
    ) u_prerot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dx    (dx),
        .dy    (dy),
        .p     (p_pipe[0]),
        .q     (q_pipe[0]),
        .z     (z_pipe[0]),
        .ctl   (c_pipe[0])
    );

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        hac_cell #(
            .W    (W),
            .STEP (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .p_in    (p_pipe[i]),
            .q_in    (q_pipe[i]),
            .z_in    (z_pipe[i]),
            .ctl_in  (c_pipe[i]),
            .p_out   (p_pipe[i+1]),
            .q_out   (q_pipe[i+1]),
            .z_out   (z_pipe[i+1]),
            .ctl_out (c_pipe[i+1])
        );
    end

    hac_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .z       (z_pipe[ITERATIONS]),
        .ctl     (c_pipe[ITERATIONS]),
        .done    (done),
        .heading (heading)
    );

`ifndef SYNTH
    a_done_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without request");

    a_req_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("request lost in pipe");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(dx, LAT) == '0 && $past(dy, LAT) == '0) |-> heading == '0)
        else $error("zero offset gives nonzero heading");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (ANGLE_FRAC_BITS > 7
                  || (heading <= 16'sd23040 && heading >= -16'sd23040)))
        else $error("heading out of range");
`endif

endmodule

@@ rtl/hac_prerot.sv @@
`timescale 1ns / 1ps

module hac_prerot
    import hac_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int W          = 27
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [15:0]  dx,
    input  logic signed [15:0]  dy,
    output logic signed [W-1:0] p,
    output logic signed [W-1:0] q,
    output zang_t               z,
    output hac_ctl_t            ctl
);

    logic signed [EXT_W-1:0]      dx_ext;
    logic signed [EXT_W-1:0]      dy_ext;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [W-1:0]          pv;
    logic signed [W-1:0]          qv;
    logic signed [W-1:0]          p_reg, p_next;
    logic signed [W-1:0]          q_reg, q_next;
    zang_t                        z_reg, z_next;
    hac_ctl_t                     ctl_reg, ctl_next;

    always_comb
    begin
        dx_ext = EXT_W'(dx);
        dy_ext = EXT_W'(dy);
        cx     = dx_ext[COORD_BITS-1:0];
        cy     = dy_ext[COORD_BITS-1:0];
        pv     = W'(cy) <<< GUARD_SHIFT;
        qv     = -(W'(cx) <<< GUARD_SHIFT);

        p_next = pv;
        q_next = qv;
        z_next = '0;
        if (pv < 0)
        begin
            if (qv > 0)
            begin
                p_next = qv;
                q_next = -pv;
                z_next = Z_P90;
            end
            else
            begin
                p_next = -qv;
                q_next = pv;
                z_next = -Z_P90;
            end
        end

        ctl_next.vld = start;
        if (cx == '0)
            ctl_next.sp = (cy < 0) ? SP_180 : SP_ZERO;
        else if (cy == '0)
            ctl_next.sp = (cx > 0) ? SP_M90 : SP_P90;
        else
            ctl_next.sp = SP_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
        z_reg <= z_next;
    end

    assign p   = p_reg;
    assign q   = q_reg;
    assign z   = z_reg;
    assign ctl = ctl_reg;

endmodule

@@ rtl/hac_cell.sv @@
`timescale 1ns / 1ps

module hac_cell
    import hac_pkg::*;
#(
    parameter int W    = 27,
    parameter int STEP = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [W-1:0] p_in,
    input  logic signed [W-1:0] q_in,
    input  zang_t               z_in,
    input  hac_ctl_t            ctl_in,
    output logic signed [W-1:0] p_out,
    output logic signed [W-1:0] q_out,
    output zang_t               z_out,
    output hac_ctl_t            ctl_out
);

    localparam zang_t ANG = atan_tab(5'(STEP));

    logic signed [W-1:0] p_sh;
    logic signed [W-1:0] q_sh;
    logic signed [W-1:0] p_reg, p_next;
    logic signed [W-1:0] q_reg, q_next;
    zang_t               z_reg, z_next;
    hac_ctl_t            ctl_reg;

    always_comb
    begin
        p_sh = p_in >>> STEP;
        q_sh = q_in >>> STEP;
        if (q_in >= 0)
        begin
            p_next = p_in + q_sh;
            q_next = q_in - p_sh;
            z_next = z_in + ANG;
        end
        else
        begin
            p_next = p_in - q_sh;
            q_next = q_in + p_sh;
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
        z_reg <= z_next;
    end

    assign p_out   = p_reg;
    assign q_out   = q_reg;
    assign z_out   = z_reg;
    assign ctl_out = ctl_reg;

endmodule

@@ rtl/hac_post.sv @@
`timescale 1ns / 1ps

module hac_post
    import hac_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 7
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  zang_t                    z,
    input  hac_ctl_t                 ctl,
    output logic                     done,
    output logic signed [HEAD_W-1:0] heading
);

    localparam int    SH   = Z_FRAC - ANGLE_FRAC_BITS;
    localparam zang_t HALF = zang_t'(1) <<< (SH - 1);
    localparam zang_t LIM  = zang_t'(180) <<< ANGLE_FRAC_BITS;
    localparam zang_t A90  = zang_t'(90) <<< ANGLE_FRAC_BITS;
    localparam zang_t M90  = -A90;

    zang_t                     rnd;
    zang_t                     sat;
    logic                      done_reg;
    logic signed [HEAD_W-1:0]  heading_reg, heading_next;

    always_comb
    begin
        rnd = (z + HALF) >>> SH;
        if (rnd > LIM)
            sat = LIM;
        else if (rnd < -LIM)
            sat = -LIM;
        else
            sat = rnd;

        case (ctl.sp)
            SP_NONE: heading_next = sat[HEAD_W-1:0];
            SP_ZERO: heading_next = '0;
            SP_180:  heading_next = LIM[HEAD_W-1:0];
            SP_M90:  heading_next = M90[HEAD_W-1:0];
            SP_P90:  heading_next = A90[HEAD_W-1:0];
            default: heading_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= heading_next;
    end

    assign done    = done_reg;
    assign heading = heading_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import hac_pkg::*;

    localparam int ITERS      = 16;
    localparam int FRAC_BITS  = 7;
    localparam int N_RANDOM   = 1950;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_CAP  = 500;
    localparam longint HALF_TURN = 180 * (64'sd1 <<< FRAC_BITS);

    typedef logic signed [IN_W-1:0]   coord_t;
    typedef logic signed [HEAD_W-1:0] heading_t;

    class heading_board;
        heading_t pending_q[$];
        longint   atan_step[TAB_LEN];
        int       errors;
        int       n_requests;
        int       n_checked;
        int       n_axis;

        function new();
            atan_step = '{754974720, 445687602, 235489088, 119537938,
                          60000934, 30029717, 15018523, 7509720,
                          3754917, 1877466, 938734, 469367,
                          234684, 117342, 58671, 29335,
                          14668, 7334, 3667, 1833,
                          917, 458, 229, 115};
            errors     = 0;
            n_requests = 0;
            n_checked  = 0;
            n_axis     = 0;
        endfunction

        function heading_t predict_heading(coord_t x, coord_t y);
            longint p, q, z, np, nq, t;
            int     sh;
            if (x == 0)
                return (y < 0) ? heading_t'(HALF_TURN) : heading_t'(0);
            if (y == 0)
                return (x > 0) ? heading_t'(-HALF_TURN / 2) : heading_t'(HALF_TURN / 2);
            p = longint'(y) <<< GUARD_SHIFT;
            q = -(longint'(x) <<< GUARD_SHIFT);
            z = 0;
            if (p < 0)
            begin
                t = p;
                if (q > 0)
                begin
                    p = q;
                    q = -t;
                    z = 90 * (64'sd1 <<< Z_FRAC);
                end
                else
                begin
                    p = -q;
                    q = t;
                    z = -90 * (64'sd1 <<< Z_FRAC);
                end
            end
            for (int i = 0; i < ITERS; i++)
            begin
                if (q >= 0)
                begin
                    np = p + (q >>> i);
                    nq = q - (p >>> i);
                    z  = z + atan_step[i];
                end
                else
                begin
                    np = p - (q >>> i);
                    nq = q + (p >>> i);
                    z  = z - atan_step[i];
                end
                p = np;
                q = nq;
            end
            sh = Z_FRAC - FRAC_BITS;
            z  = (z + (64'sd1 <<< (sh - 1))) >>> sh;
            if (z > HALF_TURN)
                z = HALF_TURN;
            if (z < -HALF_TURN)
                z = -HALF_TURN;
            return heading_t'(z);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch @%0t: %s", $realtime, what);
        endtask

        function void note_request(coord_t x, coord_t y);
            pending_q.push_back(predict_heading(x, y));
            n_requests++;
            if (x == 0 || y == 0)
                n_axis++;
        endfunction

        task check_heading(heading_t got);
            heading_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("heading %0d with no request outstanding", got));
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got !== want)
                report($sformatf("heading %0d, expected %0d", got, want));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    coord_t   dx;
    coord_t   dy;
    logic     done;
    heading_t heading;

    heading_board board;
    int           cycles = 0;

    heading_angle_atan2_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .dx      (dx),
        .dy      (dy),
        .done    (done),
        .heading (heading)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_request(dx, dy);
            if (done)
                board.check_heading(heading);
        end
    end

    task automatic send_request(input coord_t x, input coord_t y, input int gap);
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        dx    <= x;
        dy    <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic coord_t edge_value();
        case ($urandom_range(0, 5))
            0:       return coord_t'(-32768);
            1:       return coord_t'(-32767);
            2:       return coord_t'(-1);
            3:       return coord_t'(0);
            4:       return coord_t'(1);
            default: return coord_t'(32767);
        endcase
    endfunction

    task automatic random_pair(output coord_t x, output coord_t y);
        int kind;
        kind = $urandom_range(0, 9);
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        case (kind)
            5, 6:
            begin
                x = coord_t'(int'($urandom_range(0, 64)) - 32);
                y = coord_t'(int'($urandom_range(0, 64)) - 32);
            end
            7:
            begin
                if ($urandom_range(0, 1))
                    x = '0;
                else
                    y = '0;
            end
            8:
            begin
                // near the diagonals, where quadrant decisions flip
                y = ($urandom_range(0, 1)) ? x : -x;
                y = y + coord_t'(int'($urandom_range(0, 6)) - 3);
            end
            9:
            begin
                x = edge_value();
                y = edge_value();
            end
            default:
            begin
            end
        endcase
    endtask

    coord_t dir_x[$] = '{0, 0, 0, 0, 0, 5, -5, 32767, -32768, 0,
                         1, -1, 1, -1, 32767, -32768, -32768, 32767,
                         1, -1, 100, -100, 1, 32767};
    coord_t dir_y[$] = '{5, -5, 0, 32767, -32768, 0, 0, 0, 0, 1,
                         1, 1, -1, -1, 32767, -32768, 32767, -32768,
                         -32768, -32768, -100, 100, 32767, -1};

    initial
    begin
        coord_t x;
        coord_t y;
        int     gap;
        board  = new();
        rst_n  = 1'b0;
        start  <= 1'b0;
        dx     <= '0;
        dy     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners and axis cases
        foreach (dir_x[i])
            send_request(dir_x[i], dir_y[i], (i % 3 == 0) ? $urandom_range(0, 11) : 0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            random_pair(x, y);
            if ((n / 100) % 3 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            send_request(x, y, gap);
        end
        start <= 1'b0;

        for (int w = 0; w < DRAIN_CAP && board.pending_q.size() != 0; w++)
            @(posedge clk);
        repeat (ITERS + 4) @(posedge clk);
        if (board.pending_q.size() != 0)
            board.report($sformatf("%0d headings never arrived", board.pending_q.size()));

        $display("%0d offset pairs sent (%0d on an axis), %0d headings checked",
                 board.n_requests, board.n_axis, board.n_checked);
        $display("back-to-back and gapped requests, %0d mismatches", board.errors);
        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
